// ----- rtl/core/ssrs_pkg.sv -----
// ----------------------------------------------------------------------------
// ssrs_pkg
// Shared types and constants for the serial RAM command sequencer.
// ----------------------------------------------------------------------------
package ssrs_pkg;

	typedef enum logic [6:0] {
		PH_IDLE     = 7'b0000001,
		PH_POLL_CMD = 7'b0000010,
		PH_POLL_RD  = 7'b0000100,
		PH_WREN     = 7'b0001000,
		PH_OPCODE   = 7'b0010000,
		PH_ADDR     = 7'b0100000,
		PH_DATA     = 7'b1000000
	} phase_t;

	localparam logic [7:0] DUMMY_BYTE = 8'hFF;

	// configuration register indexes
	localparam logic [2:0] REG_OPCODE_SET     = 3'd0;
	localparam logic [2:0] REG_BUSY_MASK      = 3'd1;
	localparam logic [2:0] REG_DEVICE_IDS     = 3'd2;
	localparam logic [2:0] REG_DEVICE_OPTIONS = 3'd3;
	localparam logic [2:0] REG_PAGE_SIZE_LOG  = 3'd4;

	localparam logic [31:0] OPCODE_SET_RST     = 32'h0506_0203;
	localparam logic [7:0]  BUSY_MASK_RST      = 8'h01;
	localparam logic [15:0] DEVICE_IDS_RST     = 16'h0100;
	localparam logic [9:0]  DEVICE_OPTIONS_RST = 10'd99;
	localparam logic [4:0]  PAGE_SIZE_LOG_RST  = 5'd5;

	// per-device option bits
	localparam int OPT_PRESENT = 0;
	localparam int OPT_ADDR3   = 1;
	localparam int OPT_POLL    = 2;
	localparam int OPT_WLATCH  = 3;
	localparam int OPT_PSPLIT  = 4;

	// opcode slots inside opcode_set
	localparam logic [1:0] OPC_READ   = 2'd0;
	localparam logic [1:0] OPC_WRITE  = 2'd1;
	localparam logic [1:0] OPC_WREN   = 2'd2;
	localparam logic [1:0] OPC_STATUS = 2'd3;

	localparam logic [4:0] PAGE_LOG_FULL = 5'd24;

	typedef struct packed {
		logic [31:0] opcode_set;
		logic [7:0]  busy_mask;
		logic [15:0] device_ids;
		logic [9:0]  device_options;
		logic [4:0]  page_size_log;
	} cfg_t;

	typedef struct packed {
		logic        req_type;
		logic        write_op;
		logic [7:0]  device_id;
		logic [23:0] mem_address;
		logic [23:0] length;
		logic [7:0]  wr_data;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic [1:0] chip_select;
		logic       data_taken;
		logic       read_valid;
		logic [7:0] read_byte;
		logic       done_res;
		logic       status;
	} res_t;

endpackage

// ----- rtl/core/ssrs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ssrs_cfg_regs
// Configuration register file, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module ssrs_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	output ssrs_pkg::cfg_t      cfg
);

	ssrs_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.opcode_set     <= ssrs_pkg::OPCODE_SET_RST;
			cfg_q.busy_mask      <= ssrs_pkg::BUSY_MASK_RST;
			cfg_q.device_ids     <= ssrs_pkg::DEVICE_IDS_RST;
			cfg_q.device_options <= ssrs_pkg::DEVICE_OPTIONS_RST;
			cfg_q.page_size_log  <= ssrs_pkg::PAGE_SIZE_LOG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ssrs_pkg::REG_OPCODE_SET:     cfg_q.opcode_set     <= cfg_data;
				ssrs_pkg::REG_BUSY_MASK:      cfg_q.busy_mask      <= cfg_data[7:0];
				ssrs_pkg::REG_DEVICE_IDS:     cfg_q.device_ids     <= cfg_data[15:0];
				ssrs_pkg::REG_DEVICE_OPTIONS: cfg_q.device_options <= cfg_data[9:0];
				ssrs_pkg::REG_PAGE_SIZE_LOG:  cfg_q.page_size_log  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/ssrs_seq_core.sv -----
// ----------------------------------------------------------------------------
// ssrs_seq_core
// Sequencer state and the one-step update that turns an item into a result.
// ----------------------------------------------------------------------------
module ssrs_seq_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  ssrs_pkg::item_t     item,
	input  ssrs_pkg::cfg_t      cfg,
	output ssrs_pkg::res_t      res
);

	ssrs_pkg::phase_t phase_q, phase_d;
	logic        active_device_q, active_device_d;
	logic        writing_q, writing_d;
	logic [23:0] next_address_q, next_address_d;
	logic [23:0] bytes_left_q, bytes_left_d;
	logic [1:0]  addr_idx_q, addr_idx_d;

	function automatic logic [7:0] opcode_byte(input logic [31:0] set, input logic [1:0] k);
		logic [7:0] b;
		begin
			case (k)
				2'd0:    b = set[7:0];
				2'd1:    b = set[15:8];
				2'd2:    b = set[23:16];
				default: b = set[31:24];
			endcase
			return b;
		end
	endfunction

	function automatic logic [7:0] addr_byte(input logic [23:0] a, input logic [1:0] idx);
		logic [7:0] b;
		begin
			case (idx)
				2'd0:    b = a[7:0];
				2'd1:    b = a[15:8];
				2'd2:    b = a[23:16];
				default: b = 8'h00;
			endcase
			return b;
		end
	endfunction

	// device and direction of the command being opened
	logic        dev_match0, dev_match1, start_dev;
	logic        cmd_dev, cmd_wr;
	logic [4:0]  cmd_opts, act_opts;
	logic [1:0]  cmd_cs, act_cs;
	ssrs_pkg::phase_t sendop_phase, begin_phase;
	logic [7:0]  sendop_byte, begin_byte;
	logic [23:0] page_mask;
	logic [23:0] bl_dec;
	logic [1:0]  idx_dec;

	always_comb begin
		dev_match0 = (item.device_id == cfg.device_ids[7:0]);
		dev_match1 = (item.device_id == cfg.device_ids[15:8]);
		start_dev  = !dev_match0;
		cmd_dev    = item.req_type ? active_device_q : start_dev;
		cmd_wr     = item.req_type ? writing_q : item.write_op;
		cmd_opts   = cmd_dev ? cfg.device_options[9:5] : cfg.device_options[4:0];
		act_opts   = active_device_q ? cfg.device_options[9:5] : cfg.device_options[4:0];
		cmd_cs     = {cmd_dev, !cmd_dev};
		act_cs     = {active_device_q, !active_device_q};

		// write enable first when the device has a write latch
		if (cmd_wr && cmd_opts[ssrs_pkg::OPT_WLATCH]) begin
			sendop_phase = ssrs_pkg::PH_WREN;
			sendop_byte  = opcode_byte(cfg.opcode_set, ssrs_pkg::OPC_WREN);
		end else begin
			sendop_phase = ssrs_pkg::PH_OPCODE;
			sendop_byte  = opcode_byte(cfg.opcode_set,
				cmd_wr ? ssrs_pkg::OPC_WRITE : ssrs_pkg::OPC_READ);
		end
		if (cmd_opts[ssrs_pkg::OPT_POLL]) begin
			begin_phase = ssrs_pkg::PH_POLL_CMD;
			begin_byte  = opcode_byte(cfg.opcode_set, ssrs_pkg::OPC_STATUS);
		end else begin
			begin_phase = sendop_phase;
			begin_byte  = sendop_byte;
		end

		if (cfg.page_size_log >= ssrs_pkg::PAGE_LOG_FULL)
			page_mask = 24'hFF_FFFF;
		else
			page_mask = ~(24'hFF_FFFF << cfg.page_size_log);

		bl_dec  = bytes_left_q - 24'd1;
		idx_dec = addr_idx_q - 2'd1;
	end

	always_comb begin
		phase_d         = phase_q;
		active_device_d = active_device_q;
		writing_d       = writing_q;
		next_address_d  = next_address_q;
		bytes_left_d    = bytes_left_q;
		addr_idx_d      = addr_idx_q;
		res             = '0;

		if (!item.req_type) begin
			if (phase_q != ssrs_pkg::PH_IDLE) begin
				res.chip_select = act_cs;
			end else if (item.length == 24'd0) begin
				res.done_res = 1'b1;
			end else if (!dev_match0 && !dev_match1) begin
				res.done_res = 1'b1;
				res.status   = 1'b1;
			end else begin
				active_device_d = start_dev;
				if (!cmd_opts[ssrs_pkg::OPT_PRESENT]) begin
					res.done_res = 1'b1;
					res.status   = 1'b1;
				end else begin
					writing_d       = item.write_op;
					next_address_d  = item.mem_address;
					bytes_left_d    = item.length;
					addr_idx_d      = 2'd0;
					phase_d         = begin_phase;
					res.tx_valid    = 1'b1;
					res.tx_byte     = begin_byte;
					res.chip_select = cmd_cs;
				end
			end
		end else begin
			unique case (phase_q)
				ssrs_pkg::PH_POLL_CMD: begin
					phase_d         = ssrs_pkg::PH_POLL_RD;
					res.tx_valid    = 1'b1;
					res.tx_byte     = ssrs_pkg::DUMMY_BYTE;
					res.chip_select = act_cs;
				end
				ssrs_pkg::PH_POLL_RD: begin
					res.tx_valid    = 1'b1;
					res.chip_select = act_cs;
					if ((item.rx_byte & cfg.busy_mask) != 8'h00) begin
						phase_d     = ssrs_pkg::PH_POLL_CMD;
						res.tx_byte = opcode_byte(cfg.opcode_set, ssrs_pkg::OPC_STATUS);
					end else begin
						phase_d     = sendop_phase;
						res.tx_byte = sendop_byte;
					end
				end
				ssrs_pkg::PH_WREN: begin
					phase_d         = ssrs_pkg::PH_OPCODE;
					res.tx_valid    = 1'b1;
					res.tx_byte     = opcode_byte(cfg.opcode_set, ssrs_pkg::OPC_WRITE);
					res.chip_select = act_cs;
				end
				ssrs_pkg::PH_OPCODE: begin
					phase_d         = ssrs_pkg::PH_ADDR;
					addr_idx_d      = act_opts[ssrs_pkg::OPT_ADDR3] ? 2'd2 : 2'd1;
					res.tx_valid    = 1'b1;
					res.tx_byte     = addr_byte(next_address_q, addr_idx_d);
					res.chip_select = act_cs;
				end
				ssrs_pkg::PH_ADDR: begin
					res.tx_valid    = 1'b1;
					res.chip_select = act_cs;
					if (addr_idx_q != 2'd0) begin
						addr_idx_d  = idx_dec;
						res.tx_byte = addr_byte(next_address_q, idx_dec);
					end else begin
						phase_d = ssrs_pkg::PH_DATA;
						if (writing_q) begin
							bytes_left_d   = bl_dec;
							next_address_d = next_address_q + 24'd1;
							res.tx_byte    = item.wr_data;
							res.data_taken = 1'b1;
						end else begin
							res.tx_byte = ssrs_pkg::DUMMY_BYTE;
						end
					end
				end
				ssrs_pkg::PH_DATA: begin
					if (!writing_q) begin
						bytes_left_d   = bl_dec;
						res.read_valid = 1'b1;
						res.read_byte  = item.rx_byte;
						if (bl_dec == 24'd0) begin
							phase_d      = ssrs_pkg::PH_IDLE;
							res.done_res = 1'b1;
						end else begin
							res.tx_valid    = 1'b1;
							res.tx_byte     = ssrs_pkg::DUMMY_BYTE;
							res.chip_select = act_cs;
						end
					end else if (bytes_left_q == 24'd0) begin
						phase_d      = ssrs_pkg::PH_IDLE;
						res.done_res = 1'b1;
					end else if (act_opts[ssrs_pkg::OPT_PSPLIT]
							&& (next_address_q & page_mask) == 24'd0) begin
						// page boundary: reopen the command at the next address
						phase_d         = begin_phase;
						res.tx_valid    = 1'b1;
						res.tx_byte     = begin_byte;
						res.chip_select = act_cs;
					end else begin
						bytes_left_d    = bl_dec;
						next_address_d  = next_address_q + 24'd1;
						res.tx_valid    = 1'b1;
						res.tx_byte     = item.wr_data;
						res.chip_select = act_cs;
						res.data_taken  = 1'b1;
					end
				end
				default: begin
					phase_d = ssrs_pkg::PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= ssrs_pkg::PH_IDLE;
			active_device_q <= 1'b0;
			writing_q       <= 1'b0;
			next_address_q  <= 24'd0;
			bytes_left_q    <= 24'd0;
			addr_idx_q      <= 2'd0;
		end else if (step_en) begin
			phase_q         <= phase_d;
			active_device_q <= active_device_d;
			writing_q       <= writing_d;
			next_address_q  <= next_address_d;
			bytes_left_q    <= bytes_left_d;
			addr_idx_q      <= addr_idx_d;
		end
	end

endmodule

// ----- rtl/core/spi_serial_ram_sequencer.sv -----
// ----------------------------------------------------------------------------
// spi_serial_ram_sequencer
// Command sequencer for up to two SPI serial RAM or EEPROM devices.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one item per transaction: a
// start request (req_type 0) or the report of one finished link byte
// exchange (req_type 1). Every accepted item produces exactly one result on
// the output channel (out_valid / out_stall): the next byte to send with its
// chip select, a consumed-data flag, a read payload byte, and done/status.
// Items are taken into an input register, the sequencer state is updated in
// one pass, and the result lands in an output register that drives out_valid;
// one item is accepted per cycle while out_stall does not back up the output.
// While out_stall holds the output register full, the input register still
// takes one more item, then in_stall rises until the result is taken.
// Reset clears the sequencer to idle and loads the register defaults.
// Configuration registers are written through cfg_we / cfg_index / cfg_data
// and should only change while no transaction is in flight.
// ----------------------------------------------------------------------------
module spi_serial_ram_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic        write_op,
	input  logic [7:0]  device_id,
	input  logic [23:0] mem_address,
	input  logic [23:0] length,
	input  logic [7:0]  wr_data,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic [1:0]  chip_select,
	output logic        data_taken,
	output logic        read_valid,
	output logic [7:0]  read_byte,
	output logic        done_res,
	output logic        status
);

	ssrs_pkg::cfg_t  cfg;
	ssrs_pkg::item_t item_s1;
	ssrs_pkg::res_t  res, res_q;
	logic            valid_s1;
	logic            out_valid_q;
	logic            advance;
	logic            in_take;

	ssrs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ssrs_seq_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// move the held item forward when the output register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.req_type    <= req_type;
			item_s1.write_op    <= write_op;
			item_s1.device_id   <= device_id;
			item_s1.mem_address <= mem_address;
			item_s1.length      <= length;
			item_s1.wr_data     <= wr_data;
			item_s1.rx_byte     <= rx_byte;
		end
		if (advance)
			res_q <= res;
	end

	assign out_valid   = out_valid_q;
	assign tx_valid    = res_q.tx_valid;
	assign tx_byte     = res_q.tx_byte;
	assign chip_select = res_q.chip_select;
	assign data_taken  = res_q.data_taken;
	assign read_valid  = res_q.read_valid;
	assign read_byte   = res_q.read_byte;
	assign done_res    = res_q.done_res;
	assign status      = res_q.status;

endmodule

// ----- test/spi_serial_ram_sequencer_test.sv -----
// ----------------------------------------------------------------------------
// spi_serial_ram_sequencer_test
// Self-checking bench for the serial RAM command sequencer. A queue of start
// and link-done requests, directed first and then random, is driven with
// random gaps while the result side stalls at random, save in one phase that
// runs with neither. A cycle-free model of the sequencer predicts each result
// as its request is accepted, and every result is compared field by field in
// order. Register settings change between phases, once the block has drained.
// ----------------------------------------------------------------------------
module spi_serial_ram_sequencer_test;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_GAP   = 8;
	localparam int HOLD_CYCLES = 120;

	typedef struct packed {
		ssrs_pkg::phase_t phase;
		logic        dev;
		logic        writing;
		logic [23:0] addr;
		logic [23:0] left;
		logic [1:0]  idx;
	} seq_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = ssrs_pkg::REG_OPCODE_SET;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        out_stall = 1'b0;
	ssrs_pkg::item_t drv = '0;
	logic        in_stall, out_valid, tx_valid, data_taken, read_valid, done_res, status;
	logic [7:0]  tx_byte, read_byte;
	logic [1:0]  chip_select;

	ssrs_pkg::cfg_t  cfg_m;
	seq_state_t      plan_st, chk_st;
	ssrs_pkg::item_t pending_q[$];
	ssrs_pkg::res_t  exp_q[$];
	bit          in_taken = 1'b0;
	bit          calm = 1'b0;
	bit          hold_done = 1'b0;
	int          hold_left = 0;
	int          fails = 0;
	int          made = 0;
	int          results_seen = 0;
	int          quiet_cycles = 0;

	spi_serial_ram_sequencer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(drv.req_type),
		.write_op(drv.write_op),
		.device_id(drv.device_id),
		.mem_address(drv.mem_address),
		.length(drv.length),
		.wr_data(drv.wr_data),
		.rx_byte(drv.rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tx_valid(tx_valid),
		.tx_byte(tx_byte),
		.chip_select(chip_select),
		.data_taken(data_taken),
		.read_valid(read_valid),
		.read_byte(read_byte),
		.done_res(done_res),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [23:0] page_mask(logic [4:0] lg);
		if (lg >= ssrs_pkg::PAGE_LOG_FULL) return 24'hFF_FFFF;
		return (24'd1 << lg) - 24'd1;
	endfunction

	function automatic logic [4:0] dev_opts(ssrs_pkg::cfg_t c, logic dev);
		return dev ? c.device_options[9:5] : c.device_options[4:0];
	endfunction

	function automatic logic [7:0] opc(ssrs_pkg::cfg_t c, logic [1:0] k);
		return 8'(c.opcode_set >> (8 * k));
	endfunction

	// Next byte on the link for one request, with the sequencer state advanced.
	function automatic void sequence_step(input ssrs_pkg::cfg_t c, inout seq_state_t s,
			input ssrs_pkg::item_t it, output ssrs_pkg::res_t r);
		logic [4:0] o;
		logic go_cmd, go_opc, go_data, found;
		r = '0;
		go_cmd = 1'b0;
		go_opc = 1'b0;
		go_data = 1'b0;
		found = 1'b0;
		o = dev_opts(c, s.dev);
		if (it.req_type == 1'b0) begin
			if (s.phase != ssrs_pkg::PH_IDLE) begin
				// a start in the middle of a transaction is dropped
				r.chip_select = s.dev ? 2'd2 : 2'd1;
			end else if (it.length == 24'd0) begin
				r.done_res = 1'b1;
			end else begin
				if (it.device_id == c.device_ids[7:0]) begin
					s.dev = 1'b0;
					found = 1'b1;
				end else if (it.device_id == c.device_ids[15:8]) begin
					s.dev = 1'b1;
					found = 1'b1;
				end
				o = dev_opts(c, s.dev);
				if (!found || !o[ssrs_pkg::OPT_PRESENT]) begin
					r.done_res = 1'b1;
					r.status = 1'b1;
				end else begin
					s.writing = it.write_op;
					s.addr = it.mem_address;
					s.left = it.length;
					s.idx = 2'd0;
					go_cmd = 1'b1;
				end
			end
		end else begin
			case (s.phase)
				ssrs_pkg::PH_POLL_CMD: begin
					s.phase = ssrs_pkg::PH_POLL_RD;
					r.tx_valid = 1'b1;
					r.tx_byte = ssrs_pkg::DUMMY_BYTE;
				end
				ssrs_pkg::PH_POLL_RD: begin
					if ((it.rx_byte & c.busy_mask) != 8'd0) begin
						s.phase = ssrs_pkg::PH_POLL_CMD;
						r.tx_valid = 1'b1;
						r.tx_byte = opc(c, ssrs_pkg::OPC_STATUS);
					end else begin
						go_opc = 1'b1;
					end
				end
				ssrs_pkg::PH_WREN: begin
					s.phase = ssrs_pkg::PH_OPCODE;
					r.tx_valid = 1'b1;
					r.tx_byte = opc(c, ssrs_pkg::OPC_WRITE);
				end
				ssrs_pkg::PH_OPCODE: begin
					s.phase = ssrs_pkg::PH_ADDR;
					s.idx = o[ssrs_pkg::OPT_ADDR3] ? 2'd2 : 2'd1;
					r.tx_valid = 1'b1;
					r.tx_byte = 8'(s.addr >> (8 * s.idx));
				end
				ssrs_pkg::PH_ADDR: begin
					if (s.idx != 2'd0) begin
						s.idx = s.idx - 2'd1;
						r.tx_valid = 1'b1;
						r.tx_byte = 8'(s.addr >> (8 * s.idx));
					end else begin
						go_data = 1'b1;
					end
				end
				ssrs_pkg::PH_DATA: begin
					if (!s.writing) begin
						s.left = s.left - 24'd1;
						r.read_valid = 1'b1;
						r.read_byte = it.rx_byte;
						if (s.left == 24'd0) begin
							s.phase = ssrs_pkg::PH_IDLE;
							r.done_res = 1'b1;
						end else begin
							r.tx_valid = 1'b1;
							r.tx_byte = ssrs_pkg::DUMMY_BYTE;
						end
					end else if (s.left == 24'd0) begin
						s.phase = ssrs_pkg::PH_IDLE;
						r.done_res = 1'b1;
					end else if (o[ssrs_pkg::OPT_PSPLIT] &&
							(s.addr & page_mask(c.page_size_log)) == 24'd0) begin
						// page boundary: open a fresh command at the next address
						go_cmd = 1'b1;
					end else begin
						go_data = 1'b1;
					end
				end
				default: s.phase = ssrs_pkg::PH_IDLE;
			endcase
		end
		if (go_cmd) begin
			if (o[ssrs_pkg::OPT_POLL]) begin
				s.phase = ssrs_pkg::PH_POLL_CMD;
				r.tx_valid = 1'b1;
				r.tx_byte = opc(c, ssrs_pkg::OPC_STATUS);
			end else begin
				go_opc = 1'b1;
			end
		end
		if (go_opc) begin
			r.tx_valid = 1'b1;
			if (s.writing && o[ssrs_pkg::OPT_WLATCH]) begin
				s.phase = ssrs_pkg::PH_WREN;
				r.tx_byte = opc(c, ssrs_pkg::OPC_WREN);
			end else begin
				s.phase = ssrs_pkg::PH_OPCODE;
				r.tx_byte = opc(c, s.writing ? ssrs_pkg::OPC_WRITE : ssrs_pkg::OPC_READ);
			end
		end
		if (go_data) begin
			s.phase = ssrs_pkg::PH_DATA;
			r.tx_valid = 1'b1;
			if (s.writing) begin
				s.left = s.left - 24'd1;
				s.addr = s.addr + 24'd1;
				r.tx_byte = it.wr_data;
				r.data_taken = 1'b1;
			end else begin
				r.tx_byte = ssrs_pkg::DUMMY_BYTE;
			end
		end
		if (r.tx_valid) r.chip_select = s.dev ? 2'd2 : 2'd1;
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
		fails++;
		$display("result %0d: %s expected %0h got %0h", results_seen, what, want, got);
	endtask

	// drive requests from the pending queue, holding each until accepted
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
				in_valid <= 1'b1;
				drv <= pending_q[0];
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result side stalls, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else if (!hold_done && results_seen >= 200) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && $urandom_range(99) < 9;
		end
	end

	always @(posedge clk) begin
		ssrs_pkg::res_t want;
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			sequence_step(cfg_m, chk_st, drv, want);
			exp_q.push_back(want);
			void'(pending_q.pop_front());
		end
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (exp_q.size() == 0) begin
				flag_mismatch("result with nothing pending", 32'd0, 32'd1);
			end else begin
				want = exp_q.pop_front();
				if (tx_valid !== want.tx_valid)
					flag_mismatch("tx_valid", want.tx_valid, tx_valid);
				if (tx_byte !== want.tx_byte)
					flag_mismatch("tx_byte", want.tx_byte, tx_byte);
				if (chip_select !== want.chip_select)
					flag_mismatch("chip_select", want.chip_select, chip_select);
				if (data_taken !== want.data_taken)
					flag_mismatch("data_taken", want.data_taken, data_taken);
				if (read_valid !== want.read_valid)
					flag_mismatch("read_valid", want.read_valid, read_valid);
				if (read_byte !== want.read_byte)
					flag_mismatch("read_byte", want.read_byte, read_byte);
				if (done_res !== want.done_res)
					flag_mismatch("done_res", want.done_res, done_res);
				if (status !== want.status)
					flag_mismatch("status", want.status, status);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
			quiet_cycles++;
		else
			quiet_cycles = 0;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic ssrs_pkg::item_t random_item(logic req);
		ssrs_pkg::item_t it;
		it.req_type = req;
		it.write_op = 1'($urandom);
		it.device_id = 8'($urandom);
		it.mem_address = 24'($urandom);
		it.length = 24'($urandom);
		it.wr_data = 8'($urandom);
		it.rx_byte = 8'($urandom);
		return it;
	endfunction

	// queue a request and track where the sequencer will be after it
	task automatic offer(ssrs_pkg::item_t it);
		ssrs_pkg::res_t ignored_res;
		sequence_step(cfg_m, plan_st, it, ignored_res);
		pending_q.push_back(it);
		made++;
	endtask

	// one start followed by link-done reports until the transaction ends, with stray requests when noisy
	task automatic run_transfer(logic wop, logic [7:0] dev, logic [23:0] addr,
			logic [23:0] len, bit noisy);
		ssrs_pkg::item_t it;
		it = random_item(1'b0);
		it.write_op = wop;
		it.device_id = dev;
		it.mem_address = addr;
		it.length = len;
		offer(it);
		if (noisy && plan_st.phase != ssrs_pkg::PH_IDLE) offer(random_item(1'b0));
		while (plan_st.phase != ssrs_pkg::PH_IDLE) begin
			if (noisy && $urandom_range(99) < 6) offer(random_item(1'b0));
			it = random_item(1'b1);
			// mostly let the status poll see a ready device
			if (plan_st.phase == ssrs_pkg::PH_POLL_RD && $urandom_range(99) < 75)
				it.rx_byte = it.rx_byte & ~cfg_m.busy_mask;
			offer(it);
		end
		if ($urandom_range(99) < 4) offer(random_item(1'b1));
	endtask

	task automatic random_transfer();
		logic [7:0] dev;
		logic [23:0] addr, len;
		int pick;
		pick = $urandom_range(99);
		dev = pick < 45 ? cfg_m.device_ids[7:0] :
			pick < 88 ? cfg_m.device_ids[15:8] : 8'($urandom);
		pick = $urandom_range(99);
		len = pick < 4 ? 24'd0 :
			pick < 92 ? 24'($urandom_range(1, 12)) : 24'($urandom_range(13, 70));
		addr = 24'($urandom);
		// land near a page end so writes cross it
		if ($urandom_range(99) < 40)
			addr = (addr | page_mask(cfg_m.page_size_log)) - 24'($urandom_range(0, 4));
		run_transfer(1'($urandom), dev, addr, len, $urandom_range(99) < 15);
	endtask

	task automatic settle();
		while (pending_q.size() != 0 || exp_q.size() != 0) @(posedge clk);
		repeat (DRAIN_GAP) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		case (idx)
			ssrs_pkg::REG_OPCODE_SET:     cfg_m.opcode_set = val;
			ssrs_pkg::REG_BUSY_MASK:      cfg_m.busy_mask = val[7:0];
			ssrs_pkg::REG_DEVICE_IDS:     cfg_m.device_ids = val[15:0];
			ssrs_pkg::REG_DEVICE_OPTIONS: cfg_m.device_options = val[9:0];
			ssrs_pkg::REG_PAGE_SIZE_LOG:  cfg_m.page_size_log = val[4:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic run_phase(logic [31:0] opcodes, logic [7:0] mask, logic [15:0] ids,
			logic [9:0] opts, logic [4:0] page_log, int count, bit no_gaps);
		int target;
		settle();
		write_reg(ssrs_pkg::REG_OPCODE_SET, opcodes);
		write_reg(ssrs_pkg::REG_BUSY_MASK, {24'd0, mask});
		write_reg(ssrs_pkg::REG_DEVICE_IDS, {16'd0, ids});
		write_reg(ssrs_pkg::REG_DEVICE_OPTIONS, {22'd0, opts});
		write_reg(ssrs_pkg::REG_PAGE_SIZE_LOG, {27'd0, page_log});
		cfg_we = 1'b0;
		calm = no_gaps;
		target = made + count;
		while (made < target) random_transfer();
	endtask

	initial begin
		ssrs_pkg::item_t it;
		cfg_m = {ssrs_pkg::OPCODE_SET_RST, ssrs_pkg::BUSY_MASK_RST,
			ssrs_pkg::DEVICE_IDS_RST, ssrs_pkg::DEVICE_OPTIONS_RST,
			ssrs_pkg::PAGE_SIZE_LOG_RST};
		plan_st = '0;
		plan_st.phase = ssrs_pkg::PH_IDLE;
		chk_st = plan_st;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed: zero length, unknown device, idle link-done, wrap, busy start
		it = random_item(1'b0);
		it.length = 24'd0;
		offer(it);
		it = random_item(1'b0);
		it.device_id = 8'hFF;
		it.length = 24'hFF_FFFF;
		offer(it);
		offer(random_item(1'b1));
		run_transfer(1'b0, 8'h00, 24'hAB_CDEF, 24'd2, 1'b1);
		run_transfer(1'b1, 8'h01, 24'hFF_FFFE, 24'd3, 1'b1);
		run_transfer(1'b0, 8'h01, 24'hFF_FFFF, 24'd1, 1'b0);
		run_transfer(1'b1, 8'h00, 24'h00_0000, 24'd1, 1'b0);

		run_phase(ssrs_pkg::OPCODE_SET_RST, ssrs_pkg::BUSY_MASK_RST,
			ssrs_pkg::DEVICE_IDS_RST, ssrs_pkg::DEVICE_OPTIONS_RST,
			ssrs_pkg::PAGE_SIZE_LOG_RST, 260, 1'b0);
		run_phase(32'hFFFF_FFFF, 8'hFF, 16'hFFFF, 10'h3FF, 5'd0, 220, 1'b0);
		run_phase(32'h0000_0000, 8'h80, 16'h3CA5, 10'h3DF, 5'd16, 220, 1'b0);
		run_phase($urandom, 8'($urandom), 16'h0000, 10'h3B7, ssrs_pkg::PAGE_LOG_FULL,
			220, 1'b0);
		run_phase($urandom, 8'h00, 16'h7E81, 10'h379, 5'd2, 220, 1'b1);
		run_phase($urandom, 8'($urandom), 16'($urandom), 10'($urandom) | 10'h021,
			5'($urandom_range(0, 16)), 220, 1'b0);
		settle();

		if (fails == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ----- spi_serial_ram_sequencer.f -----
rtl/core/ssrs_pkg.sv
rtl/core/ssrs_cfg_regs.sv
rtl/core/ssrs_seq_core.sv
rtl/core/spi_serial_ram_sequencer.sv
test/spi_serial_ram_sequencer_test.sv
